/* rtl/core/ptik_pkg.sv */
`default_nettype none
package ptik_pkg;

    localparam int TABLE_LEN = 24;
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HOME_X = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HOME_Y = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PLANE_DISTANCE = 2'd2;
    localparam logic [63:0] INVGAIN_Q32 = 64'd2608131496;
    localparam logic [63:0] DEG_PER_RAD_Q32 = 64'd246083499208;

    typedef struct packed {
        logic [11:0] target_x;
        logic [11:0] target_y;
    } request_t;

    typedef struct packed {
        logic [7:0] pan_command;
        logic [7:0] tilt_command;
        logic       clipped;
    } result_t;

    function automatic logic [31:0] atan_q32(input int i);
        logic [31:0] t;
        begin
            t = 32'd0;
            unique case (i)
                0: t = 32'd3373259426;
                1: t = 32'd1991351318;
                2: t = 32'd1052175346;
                3: t = 32'd534100635;
                4: t = 32'd268086748;
                5: t = 32'd134174063;
                6: t = 32'd67103404;
                7: t = 32'd33553749;
                8: t = 32'd16777131;
                9: t = 32'd8388597;
                10: t = 32'd4194303;
                11: t = 32'd2097152;
                12: t = 32'd1048576;
                13: t = 32'd524288;
                14: t = 32'd262144;
                15: t = 32'd131072;
                16: t = 32'd65536;
                17: t = 32'd32768;
                18: t = 32'd16384;
                19: t = 32'd8192;
                20: t = 32'd4096;
                21: t = 32'd2048;
                22: t = 32'd1024;
                default: t = 32'd512;
            endcase
            return t;
        end
    endfunction

    function automatic logic [63:0] q32_to_qf(input logic [63:0] t, input int f);
        begin
            return (t + (64'd1 << (31 - f))) >> (32 - f);
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/core/ptik_cordic_stage.sv */
`default_nettype none
module ptik_cordic_stage #(
    parameter int W = 48,
    parameter int STEP = 0,
    parameter int FRAC = 16,
    parameter bit ROTATE = 1'b0
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         valid,
    input  wire logic signed [W-1:0] x,
    input  wire logic signed [W-1:0] y,
    input  wire logic signed [W-1:0] z,
    output logic              valid_reg,
    output logic signed [W-1:0] x_reg,
    output logic signed [W-1:0] y_reg,
    output logic signed [W-1:0] z_reg
);

    localparam logic [63:0] ANGLE_Q =
        ptik_pkg::q32_to_qf({32'd0, ptik_pkg::atan_q32(STEP)}, FRAC);
    localparam logic signed [W-1:0] ANGLE = W'(ANGLE_Q);

    logic signed [W-1:0] x_next;
    logic signed [W-1:0] y_next;
    logic signed [W-1:0] z_next;
    logic                pos;

    always_comb
    begin
        pos = ROTATE ? (z >= 0) : (y < 0);
        if (pos)
        begin
            x_next = x - (y >>> STEP);
            y_next = y + (x >>> STEP);
            z_next = z - ANGLE;
        end
        else
        begin
            x_next = x + (y >>> STEP);
            y_next = y - (x >>> STEP);
            z_next = z + ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

endmodule
`default_nettype wire

/* rtl/core/ptik_cordic.sv */
`default_nettype none
module ptik_cordic #(
    parameter int W = 48,
    parameter int STEPS = 16,
    parameter int FRAC = 16,
    parameter bit ROTATE = 1'b0
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         valid,
    input  wire logic signed [W-1:0] x,
    input  wire logic signed [W-1:0] y,
    input  wire logic signed [W-1:0] z,
    output logic              valid_out,
    output logic signed [W-1:0] x_out,
    output logic signed [W-1:0] z_out
);

    logic              v [0:STEPS];
    logic signed [W-1:0] xs [0:STEPS];
    logic signed [W-1:0] ys [0:STEPS];
    logic signed [W-1:0] zs [0:STEPS];

    assign v[0] = valid;
    assign xs[0] = x;
    assign ys[0] = y;
    assign zs[0] = z;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        ptik_cordic_stage #(
            .W(W), .STEP(i), .FRAC(FRAC), .ROTATE(ROTATE)
        ) u_stage (
            .clk(clk), .rst_n(rst_n), .valid(v[i]),
            .x(xs[i]), .y(ys[i]), .z(zs[i]),
            .valid_reg(v[i+1]), .x_reg(xs[i+1]), .y_reg(ys[i+1]), .z_reg(zs[i+1])
        );
    end

    assign valid_out = v[STEPS];
    assign x_out = xs[STEPS];
    assign z_out = zs[STEPS];

endmodule
`default_nettype wire

/* rtl/core/ptik_command.sv */
`default_nettype none
module ptik_command #(
    parameter int W = 48,
    parameter int FRAC = 16
) (
    input  wire logic         clk,
    input  wire logic signed [W-1:0] rad,
    output logic [7:0]        command_reg,
    output logic              clip_reg
);

    localparam logic [63:0] DPR_Q = ptik_pkg::q32_to_qf(ptik_pkg::DEG_PER_RAD_Q32, FRAC);
    localparam int RW = W - FRAC + 8;
    localparam int DW = RW + FRAC + 9;
    localparam logic signed [DW-1:0] LIMIT = DW'(60) <<< FRAC;

    logic signed [RW-1:0] rad_n;
    logic signed [DW-1:0] prod_reg;
    logic signed [DW-1:0] prod_next;
    logic signed [DW-1:0] deg;
    logic signed [DW-1:0] scaled_reg;
    logic signed [DW-1:0] scaled_next;
    logic [1:0]          sat_reg;
    logic [1:0]          sat_next;
    logic [DW-1:0]        quot;

    assign rad_n = RW'(rad);
    assign prod_next = DW'(rad_n) * DW'($signed({1'b0, DPR_Q[FRAC+6:0]}));
    assign deg = prod_next >>> FRAC;

    always_ff @(posedge clk)
    begin
        prod_reg <= deg;
    end

    // The span of 255 codes over 120 degrees is exactly 17/8 codes per degree.
    always_comb
    begin
        sat_next = 2'b00;
        scaled_next = (prod_reg + LIMIT) * DW'(17);
        if (prod_reg < -LIMIT)
        begin
            sat_next = 2'b01;
        end
        else if (prod_reg > LIMIT)
        begin
            sat_next = 2'b10;
        end
    end

    always_ff @(posedge clk)
    begin
        scaled_reg <= scaled_next;
        sat_reg <= sat_next;
    end

    assign quot = scaled_reg >>> (FRAC + 3);

    always_ff @(posedge clk)
    begin
        clip_reg <= |sat_reg;
        unique case (sat_reg)
            2'b01: command_reg <= 8'd0;
            2'b10: command_reg <= 8'd255;
            default: command_reg <= quot[7:0];
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/pan_tilt_inverse_kinematics_unit.sv */
`default_nettype none
// Pan/tilt inverse kinematics unit.
// Requests enter on start with a target pixel in request; busy is always low, so
// a new request is taken every cycle. Each request yields one result on result,
// marked by done for a single cycle. Done and result are valid in the same
// cycle. Each CORDIC runs CORDIC_STEPS iterations, capped at 24. A request
// passes an input register, three CORDIC pipelines in series (pan vectoring,
// cosine rotation, tilt vectoring), one register per iteration, then a
// three-stage scaling unit that maps radians to a servo code.
// Throughput is one request per cycle.
// Configuration writes use cfg_valid/cfg_ready, cfg_index and cfg_data; ready
// is always high. Write only while no request is in flight.
// Reset clears all valid bits in the pipeline and loads home (320, 240) and a
// plane distance of 500. The receiver cannot stall; results are never held.
module pan_tilt_inverse_kinematics_unit #(
    parameter int COORD_BITS = 12,
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire ptik_pkg::request_t request,
    output logic                    done,
    output ptik_pkg::result_t       result,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [ptik_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [13:0]        cfg_data
);

    localparam int STEPS = (CORDIC_STEPS > ptik_pkg::TABLE_LEN) ?
        ptik_pkg::TABLE_LEN : CORDIC_STEPS;
    localparam int F = ANGLE_FRAC_BITS;
    localparam int W = 16 + F + 6;
    localparam logic [63:0] INVG_Q = ptik_pkg::q32_to_qf(ptik_pkg::INVGAIN_Q32, F);
    localparam int LAT = 3 * STEPS + 4;

    logic [11:0] home_x_reg;
    logic [11:0] home_y_reg;
    logic [13:0] dist_reg;
    logic [COORD_BITS-1:0] tx;
    logic [COORD_BITS-1:0] ty;
    logic [COORD_BITS-1:0] hx;
    logic [COORD_BITS-1:0] hy;
    logic signed [W-1:0] d_w;
    logic signed [W-1:0] dx_w;
    logic signed [COORD_BITS:0] dy_s;

    logic              in_v_reg;
    logic signed [W-1:0] dx_reg;
    logic signed [W-1:0] dy_reg;
    logic              pan_v;
    logic signed [W-1:0] pan_x;
    logic signed [W-1:0] pan_z;
    logic signed [W-1:0] dy_d [0:STEPS];
    logic              rot_v;
    logic signed [W-1:0] rot_x;
    logic signed [W-1:0] rot_z;
    logic signed [W-1:0] pan_d [0:2*STEPS];
    logic              tilt_v;
    logic signed [W-1:0] tilt_x;
    logic signed [W-1:0] tilt_z;
    logic              ov [0:3];
    logic [7:0]        pan_cmd;
    logic              pan_clip;
    logic [7:0]        tilt_cmd;
    logic              tilt_clip;
    logic              unused_ok;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_x_reg <= 12'd320;
            home_y_reg <= 12'd240;
            dist_reg <= 14'd500;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ptik_pkg::REG_HOME_X: home_x_reg <= cfg_data[11:0];
                ptik_pkg::REG_HOME_Y: home_y_reg <= cfg_data[11:0];
                ptik_pkg::REG_PLANE_DISTANCE: dist_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign tx = COORD_BITS'(request.target_x);
    assign ty = COORD_BITS'(request.target_y);
    assign hx = COORD_BITS'(home_x_reg);
    assign hy = COORD_BITS'(home_y_reg);
    assign d_w = W'((dist_reg == 14'd0) ? 14'd1 : dist_reg) <<< F;
    assign dx_w = (W'($signed({1'b0, tx})) - W'($signed({1'b0, hx}))) <<< F;
    assign dy_s = $signed({1'b0, hy}) - $signed({1'b0, ty});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= dx_w;
        dy_reg <= W'(dy_s) * W'($signed({1'b0, INVG_Q[23:0]}));
    end

    ptik_cordic #(.W(W), .STEPS(STEPS), .FRAC(F), .ROTATE(1'b0)) u_pan (
        .clk(clk), .rst_n(rst_n), .valid(in_v_reg),
        .x(d_w), .y(dx_reg), .z('0),
        .valid_out(pan_v), .x_out(pan_x), .z_out(pan_z)
    );

    assign dy_d[0] = dy_reg;
    for (genvar i = 0; i < STEPS; i++)
    begin : g_dy
        always_ff @(posedge clk)
        begin
            dy_d[i+1] <= dy_d[i];
        end
    end

    ptik_cordic #(.W(W), .STEPS(STEPS), .FRAC(F), .ROTATE(1'b1)) u_cos (
        .clk(clk), .rst_n(rst_n), .valid(pan_v),
        .x(dy_d[STEPS]), .y('0), .z(pan_z),
        .valid_out(rot_v), .x_out(rot_x), .z_out(rot_z)
    );

    ptik_cordic #(.W(W), .STEPS(STEPS), .FRAC(F), .ROTATE(1'b0)) u_tilt (
        .clk(clk), .rst_n(rst_n), .valid(rot_v),
        .x(d_w), .y(rot_x), .z('0),
        .valid_out(tilt_v), .x_out(tilt_x), .z_out(tilt_z)
    );

    assign pan_d[0] = pan_z;
    for (genvar i = 0; i < 2 * STEPS; i++)
    begin : g_pan
        always_ff @(posedge clk)
        begin
            pan_d[i+1] <= pan_d[i];
        end
    end

    ptik_command #(.W(W), .FRAC(F)) u_pan_cmd (
        .clk(clk), .rad(pan_d[2*STEPS]), .command_reg(pan_cmd), .clip_reg(pan_clip)
    );

    ptik_command #(.W(W), .FRAC(F)) u_tilt_cmd (
        .clk(clk), .rad(tilt_z), .command_reg(tilt_cmd), .clip_reg(tilt_clip)
    );

    assign ov[0] = tilt_v;
    for (genvar i = 0; i < 3; i++)
    begin : g_ov
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ov[i+1] <= 1'b0;
            end
            else
            begin
                ov[i+1] <= ov[i];
            end
        end
    end

    assign done = ov[3];
    assign result.pan_command = pan_cmd;
    assign result.tilt_command = tilt_cmd;
    assign result.clipped = pan_clip | tilt_clip;

    assign unused_ok = ^{pan_x, rot_z, tilt_x, LAT[0]};

endmodule
`default_nettype wire

/* tb/pan_tilt_inverse_kinematics_unit_test.sv */
`default_nettype none
module pan_tilt_inverse_kinematics_unit_test;

    localparam int FRAC = 16;
    localparam int STEPS = 16;
    localparam longint ONE = longint'(1) << FRAC;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 70;
    localparam logic [ptik_pkg::CFG_INDEX_BITS-1:0] REG_UNMAPPED = 2'd3;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    ptik_pkg::request_t request;
    logic done;
    ptik_pkg::result_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [ptik_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [13:0] cfg_data;

    logic [11:0] home_x_now;
    logic [11:0] home_y_now;
    logic [13:0] distance_now;
    ptik_pkg::result_t pending_commands[$];
    int error_count = 0;
    longint cycle_count = 0;
    int burst_left;

    longint arctan_q32[ptik_pkg::TABLE_LEN] = '{
        64'd3373259426, 1991351318, 1052175346, 534100635,
        268086748, 134174063, 67103404, 33553749,
        16777131, 8388597, 4194303, 2097152,
        1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512
    };

    pan_tilt_inverse_kinematics_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint round_q32(input longint t);
        return (t + (longint'(1) << (31 - FRAC))) >>> (32 - FRAC);
    endfunction

    function automatic longint vector_angle(input longint x, input longint y);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - round_q32(arctan_q32[i]);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + round_q32(arctan_q32[i]);
            end
        end
        return z;
    endfunction

    function automatic longint rotated_x(input longint x, input longint z);
        longint y;
        longint xs;
        longint ys;
        y = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - round_q32(arctan_q32[i]);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + round_q32(arctan_q32[i]);
            end
        end
        return x;
    endfunction

    function automatic logic [7:0] servo_code(input longint rad, inout logic clip);
        longint deg;
        deg = (rad * round_q32(longint'(ptik_pkg::DEG_PER_RAD_Q32))) >>> FRAC;
        if (deg < -60 * ONE)
        begin
            clip = 1'b1;
            return 8'd0;
        end
        if (deg > 60 * ONE)
        begin
            clip = 1'b1;
            return 8'd255;
        end
        return 8'(((deg + 60 * ONE) * 255) / (120 * ONE));
    endfunction

    function automatic ptik_pkg::result_t aim_turret(input logic [11:0] tx,
                                                     input logic [11:0] ty);
        ptik_pkg::result_t r;
        longint d;
        longint dx;
        longint dy;
        longint pan;
        longint tilt;
        logic clip;
        clip = 1'b0;
        d = (distance_now == 0) ? 1 : longint'(distance_now);
        dx = longint'(tx) - longint'(home_x_now);
        dy = longint'(home_y_now) - longint'(ty);
        pan = vector_angle(d * ONE, dx * ONE);
        tilt = vector_angle(d * ONE,
                            rotated_x(dy * round_q32(longint'(ptik_pkg::INVGAIN_Q32)), pan));
        r.pan_command = servo_code(pan, clip);
        r.tilt_command = servo_code(tilt, clip);
        r.clipped = clip;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("pan_tilt_inverse_kinematics_unit_test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_commands.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                ptik_pkg::result_t want;
                want = pending_commands.pop_front();
                if (result.pan_command !== want.pan_command)
                    report_mismatch("pan_command", result.pan_command, want.pan_command);
                if (result.tilt_command !== want.tilt_command)
                    report_mismatch("tilt_command", result.tilt_command, want.tilt_command);
                if (result.clipped !== want.clipped)
                    report_mismatch("clipped", result.clipped, want.clipped);
            end
        end
    end

    task automatic send_target(input logic [11:0] tx, input logic [11:0] ty);
        start <= 1'b1;
        request <= '{target_x: tx, target_y: ty};
        do
            @(posedge clk);
        while (busy);
        pending_commands.push_back(aim_turret(tx, ty));
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        else
            burst_left--;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_commands.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [ptik_pkg::CFG_INDEX_BITS-1:0] index,
                                  input logic [13:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            ptik_pkg::REG_HOME_X: home_x_now = value[11:0];
            ptik_pkg::REG_HOME_Y: home_y_now = value[11:0];
            ptik_pkg::REG_PLANE_DISTANCE: distance_now = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic test_reset_settings();
        send_target(12'd320, 12'd240);
        send_target(12'd0, 12'd0);
        send_target(12'd4095, 12'd4095);
        send_target(12'd0, 12'd4095);
        send_target(12'd4095, 12'd0);
        send_target(12'd820, 12'd240);
        send_target(12'd320, 12'd740);
        send_target(12'd321, 12'd239);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        write_register(ptik_pkg::REG_HOME_X, 14'h3FFF);
        write_register(ptik_pkg::REG_HOME_Y, 14'h3000);
        write_register(ptik_pkg::REG_PLANE_DISTANCE, 14'd16383);
        send_target(12'd0, 12'd0);
        send_target(12'd4095, 12'd4095);
        send_target(12'd4095, 12'd0);
        wait_idle();
        write_register(ptik_pkg::REG_PLANE_DISTANCE, 14'd0);
        write_register(ptik_pkg::REG_HOME_X, 14'd0);
        write_register(ptik_pkg::REG_HOME_Y, 14'd4095);
        send_target(12'd0, 12'd4095);
        send_target(12'd1, 12'd4094);
        send_target(12'd4095, 12'd0);
        wait_idle();
        write_register(ptik_pkg::REG_PLANE_DISTANCE, 14'd1);
        write_register(REG_UNMAPPED, 14'd77);
        send_target(12'd0, 12'd4095);
        send_target(12'd2, 12'd4093);
        send_target(12'd2048, 12'd2048);
        wait_idle();
    endtask

    task automatic test_random_targets();
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
                write_register(ptik_pkg::REG_PLANE_DISTANCE, 14'd16383);
            else if (phase == 1)
                write_register(ptik_pkg::REG_PLANE_DISTANCE, 14'd1);
            else
                write_register(ptik_pkg::REG_PLANE_DISTANCE, 14'($urandom_range(1, 3000)));
            write_register(ptik_pkg::REG_HOME_X, 14'($urandom));
            write_register(ptik_pkg::REG_HOME_Y, 14'($urandom));
            if ($urandom_range(0, 3) == 0)
                write_register(REG_UNMAPPED, 14'($urandom));
            for (int n = 0; n < 150; n++)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_target(12'($urandom), 12'($urandom));
                else
                    send_target(12'(home_x_now + $urandom_range(0, 2 * distance_now + 4)
                                    - distance_now - 2),
                                12'(home_y_now + $urandom_range(0, 2 * distance_now + 4)
                                    - distance_now - 2));
            end
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        burst_left = 0;
        home_x_now = 12'd320;
        home_y_now = 12'd240;
        distance_now = 14'd500;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_settings();
        test_register_extremes();
        test_random_targets();
        if (error_count == 0)
            $display("pan_tilt_inverse_kinematics_unit_test passed");
        else
            $display("pan_tilt_inverse_kinematics_unit_test failed");
        $finish;
    end
endmodule
`default_nettype wire
